>>> hdl/kpi_pkg.sv
// ---------------------------------------------------------------------------
// kpi_pkg
// shared types and constants of the keyframe pose interpolator
// ---------------------------------------------------------------------------
package kpi_pkg;

	localparam int MAX_KEYS = 128;
	localparam int CH_W     = 32;
	localparam int NCH      = 5;
	localparam int ADDR_W   = $clog2(MAX_KEYS);
	localparam int CNT_W    = $clog2(MAX_KEYS + 1);
	localparam int ROW_W    = NCH * CH_W;
	localparam int DIV_W    = CH_W + 1;
	localparam int DCNT_W   = $clog2(DIV_W + 1);
	localparam logic [7:0] STEPS_RESET = 8'd90;

	typedef enum logic [1:0] {
		OP_TICK   = 2'd0,
		OP_APPEND = 2'd1,
		OP_CLEAR  = 2'd2,
		OP_START  = 2'd3
	} opcode_t;

	typedef enum logic [1:0] {
		ST_OK      = 2'd0,
		ST_FULL    = 2'd1,
		ST_REFUSED = 2'd2
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_RD_A,
		S_RD_B,
		S_CAP_B,
		S_DIV_GO,
		S_DIV_WAIT
	} state_t;

endpackage

>>> hdl/kpi_ram.sv
// ---------------------------------------------------------------------------
// kpi_ram
// single port ram with registered read
// ---------------------------------------------------------------------------
module kpi_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 128
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		rdata <= mem[addr];
	end

endmodule

>>> hdl/kpi_div.sv
// ---------------------------------------------------------------------------
// kpi_div
// bit serial signed divider, truncating, by an 8 bit unsigned divisor
// ---------------------------------------------------------------------------
module kpi_div (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic signed [kpi_pkg::DIV_W-1:0] dividend,
	input  logic [7:0]                  divisor,
	output logic                        done,
	output logic [kpi_pkg::CH_W-1:0]    quotient
);

	logic [kpi_pkg::DIV_W-1:0]  mag_q;
	logic [7:0]                 rem_q;
	logic [7:0]                 den_q;
	logic                       neg_q;
	logic [kpi_pkg::DCNT_W-1:0] cnt_q;
	logic                       done_q;
	logic [8:0]                 rem_sh;
	logic                       fits;
	logic [kpi_pkg::DIV_W-1:0]  signed_q;

	assign rem_sh   = {rem_q, mag_q[kpi_pkg::DIV_W-1]};
	assign fits     = rem_sh >= {1'b0, den_q};
	assign signed_q = neg_q ? (~mag_q + 1'b1) : mag_q;
	assign quotient = signed_q[kpi_pkg::CH_W-1:0];
	assign done     = done_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				cnt_q <= kpi_pkg::DCNT_W'(kpi_pkg::DIV_W);
			end else if (cnt_q != '0) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == kpi_pkg::DCNT_W'(1)) begin
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			mag_q <= dividend[kpi_pkg::DIV_W-1] ? (~dividend + 1'b1) : dividend;
			neg_q <= dividend[kpi_pkg::DIV_W-1];
			rem_q <= '0;
			den_q <= divisor;
		end else if (cnt_q != '0) begin
			rem_q <= fits ? 8'(rem_sh - {1'b0, den_q}) : rem_sh[7:0];
			mag_q <= {mag_q[kpi_pkg::DIV_W-2:0], fits};
		end
	end

	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done) else $error("divider done longer than one cycle");
	a_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		start |-> cnt_q == '0) else $error("divider restarted while busy");
	a_done_after: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(cnt_q) == kpi_pkg::DCNT_W'(1))
		else $error("divider done without last step");

endmodule

>>> hdl/keyframe_pose_interpolator_core.sv
// ---------------------------------------------------------------------------
// keyframe_pose_interpolator_core
// keyframe table with linear interpolation of a five channel pose
// ---------------------------------------------------------------------------
// tick without segment change, append, clear and refused requests: done in the cycle after the request
// start and segment change: done after the table reads in S_RD_A, S_RD_B and
// S_CAP_B, then five serial divisions, one per channel, through one divider
// busy stays high until done; one request at a time, results cannot be stalled
// reset clears pose, increments, counters and playback; table is undefined
module keyframe_pose_interpolator_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [1:0]  opcode,
	input  logic signed [31:0] key_x,
	input  logic signed [31:0] key_y,
	input  logic signed [31:0] key_z,
	input  logic signed [31:0] key_heading,
	input  logic signed [31:0] key_gear,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [7:0]  cfg_data,
	output logic        done,
	output logic signed [31:0] pose_x,
	output logic signed [31:0] pose_y,
	output logic signed [31:0] pose_z,
	output logic signed [31:0] pose_heading,
	output logic signed [31:0] pose_gear,
	output logic        playing,
	output logic [7:0]  frame_total,
	output logic [1:0]  status
);

	localparam int CW = kpi_pkg::CH_W;

	kpi_pkg::state_t state_q, state_d;

	logic [7:0]                 steps_q;
	logic [7:0]                 eff_steps;
	logic [CW-1:0]              cur_q [kpi_pkg::NCH];
	logic [CW-1:0]              inc_q [kpi_pkg::NCH];
	logic [kpi_pkg::CNT_W-1:0]  count_q;
	logic [kpi_pkg::ADDR_W-1:0] seg_q;
	logic [7:0]                 step_q;
	logic                       running_q;
	logic                       is_start_q;
	logic                       done_q;
	kpi_pkg::status_t           status_q;
	logic [2:0]                 ch_q;
	logic [kpi_pkg::ROW_W-1:0]  row_a_q;
	logic [kpi_pkg::ROW_W-1:0]  row_b_q;

	logic                       req;
	logic                       ram_we;
	logic [kpi_pkg::ADDR_W-1:0] ram_addr;
	logic [kpi_pkg::ROW_W-1:0]  ram_wdata;
	logic [kpi_pkg::ROW_W-1:0]  ram_rdata;
	logic                       div_start;
	logic                       div_done;
	logic [CW-1:0]              div_q;
	logic signed [kpi_pkg::DIV_W-1:0] diff;
	logic [CW-1:0]              va, vb;
	logic [kpi_pkg::ADDR_W:0]   seg_end;

	assign req         = start && (state_q == kpi_pkg::S_IDLE);
	assign busy        = state_q != kpi_pkg::S_IDLE;
	assign cfg_ready   = 1'b1;
	assign eff_steps   = (steps_q == 8'd0) ? 8'd1 : steps_q;
	assign ram_wdata   = {key_gear, key_heading, key_z, key_y, key_x};
	assign va          = row_a_q[ch_q*CW +: CW];
	assign vb          = row_b_q[ch_q*CW +: CW];
	assign diff        = $signed({vb[CW-1], vb}) - $signed({va[CW-1], va});
	assign seg_end     = {1'b0, seg_q} + (kpi_pkg::ADDR_W+1)'(3);

	assign done         = done_q;
	assign pose_x       = cur_q[0][31:0];
	assign pose_y       = cur_q[1][31:0];
	assign pose_z       = cur_q[2][31:0];
	assign pose_heading = cur_q[3][31:0];
	assign pose_gear    = cur_q[4][31:0];
	assign playing      = running_q;
	assign frame_total  = 8'(count_q);
	assign status       = status_q;

	kpi_ram #(
		.WIDTH(kpi_pkg::ROW_W),
		.DEPTH(kpi_pkg::MAX_KEYS)
	) u_table (
		.clk  (clk),
		.we   (ram_we),
		.addr (ram_addr),
		.wdata(ram_wdata),
		.rdata(ram_rdata)
	);

	kpi_div u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (div_start),
		.dividend(diff),
		.divisor (eff_steps),
		.done    (div_done),
		.quotient(div_q)
	);

	always_comb begin
		state_d   = state_q;
		ram_we    = 1'b0;
		ram_addr  = seg_q;
		div_start = 1'b0;
		unique case (state_q)
			kpi_pkg::S_IDLE: begin
				ram_addr = count_q[kpi_pkg::ADDR_W-1:0];
				if (req) begin
					if (opcode == kpi_pkg::OP_APPEND
						&& count_q < kpi_pkg::CNT_W'(kpi_pkg::MAX_KEYS)) begin
						ram_we = 1'b1;
					end
					if (opcode == kpi_pkg::OP_START && !running_q
						&& count_q >= kpi_pkg::CNT_W'(2)) begin
						state_d = kpi_pkg::S_RD_A;
					end
					if (opcode == kpi_pkg::OP_TICK && running_q && step_q >= eff_steps
						&& !(count_q < kpi_pkg::CNT_W'(2)
						|| (kpi_pkg::CNT_W+1)'(seg_end) > (kpi_pkg::CNT_W+1)'(count_q))) begin
						state_d = kpi_pkg::S_RD_A;
					end
				end
			end
			kpi_pkg::S_RD_A: begin
				state_d = kpi_pkg::S_RD_B;
			end
			kpi_pkg::S_RD_B: begin
				ram_addr = seg_q + 1'b1;
				state_d  = kpi_pkg::S_CAP_B;
			end
			kpi_pkg::S_CAP_B: begin
				state_d = kpi_pkg::S_DIV_GO;
			end
			kpi_pkg::S_DIV_GO: begin
				div_start = 1'b1;
				state_d   = kpi_pkg::S_DIV_WAIT;
			end
			kpi_pkg::S_DIV_WAIT: begin
				if (div_done) begin
					state_d = (ch_q == 3'(kpi_pkg::NCH - 1)) ? kpi_pkg::S_IDLE
						: kpi_pkg::S_DIV_GO;
				end
			end
			default: state_d = kpi_pkg::S_IDLE;
		endcase
	end

	always_ff @(posedge clk) begin
		if (state_q == kpi_pkg::S_RD_B) begin
			row_a_q <= ram_rdata;
		end
		if (state_q == kpi_pkg::S_CAP_B) begin
			row_b_q <= ram_rdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= kpi_pkg::S_IDLE;
			steps_q    <= kpi_pkg::STEPS_RESET;
			count_q    <= '0;
			seg_q      <= '0;
			step_q     <= '0;
			running_q  <= 1'b0;
			is_start_q <= 1'b0;
			done_q     <= 1'b0;
			status_q   <= kpi_pkg::ST_OK;
			ch_q       <= '0;
			for (int c = 0; c < kpi_pkg::NCH; c++) begin
				cur_q[c] <= '0;
				inc_q[c] <= '0;
			end
		end else begin
			state_q <= state_d;
			done_q  <= 1'b0;
			if (cfg_valid && cfg_ready) begin
				steps_q <= cfg_data;
			end
			unique case (state_q)
				kpi_pkg::S_IDLE: begin
					if (req) begin
						status_q <= kpi_pkg::ST_OK;
						ch_q     <= '0;
						unique case (kpi_pkg::opcode_t'(opcode))
							kpi_pkg::OP_TICK: begin
								is_start_q <= 1'b0;
								if (running_q) begin
									if (step_q >= eff_steps) begin
										if (state_d == kpi_pkg::S_RD_A) begin
											seg_q  <= seg_q + 1'b1;
											step_q <= '0;
										end else begin
											seg_q     <= '0;
											running_q <= 1'b0;
											done_q    <= 1'b1;
										end
									end else begin
										for (int c = 0; c < kpi_pkg::NCH; c++) begin
											cur_q[c] <= cur_q[c] + inc_q[c];
										end
										step_q <= step_q + 1'b1;
										done_q <= 1'b1;
									end
								end else begin
									done_q <= 1'b1;
								end
							end
							kpi_pkg::OP_APPEND: begin
								if (ram_we) begin
									count_q <= count_q + 1'b1;
								end else begin
									status_q <= kpi_pkg::ST_FULL;
								end
								done_q <= 1'b1;
							end
							kpi_pkg::OP_CLEAR: begin
								count_q   <= '0;
								seg_q     <= '0;
								step_q    <= '0;
								running_q <= 1'b0;
								done_q    <= 1'b1;
							end
							kpi_pkg::OP_START: begin
								if (state_d == kpi_pkg::S_RD_A) begin
									is_start_q <= 1'b1;
									seg_q      <= '0;
									step_q     <= '0;
								end else begin
									status_q <= kpi_pkg::ST_REFUSED;
									done_q   <= 1'b1;
								end
							end
							default: ;
						endcase
					end
				end
				kpi_pkg::S_RD_B: begin
					if (is_start_q) begin
						for (int c = 0; c < kpi_pkg::NCH; c++) begin
							cur_q[c] <= ram_rdata[c*CW +: CW];
						end
					end
				end
				kpi_pkg::S_DIV_WAIT: begin
					if (div_done) begin
						inc_q[ch_q] <= div_q;
						ch_q        <= ch_q + 1'b1;
						if (ch_q == 3'(kpi_pkg::NCH - 1)) begin
							done_q <= 1'b1;
							if (is_start_q) begin
								running_q <= 1'b1;
							end
						end
					end
				end
				default: ;
			endcase
		end
	end

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> state_q == kpi_pkg::S_IDLE) else $error("result while busy");
	a_count_max: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= kpi_pkg::CNT_W'(kpi_pkg::MAX_KEYS)) else $error("table count overflow");
	a_play_frames: assert property (@(posedge clk) disable iff (!arst_n)
		running_q |-> count_q >= kpi_pkg::CNT_W'(2)) else $error("playing without two frames");
	a_div_wait: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> state_q == kpi_pkg::S_DIV_WAIT) else $error("stray divider result");

endmodule

>>> verif/keyframe_pose_interpolator_core_tb.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// keyframe_pose_interpolator_core_tb
// Drives append, clear, start and tick requests. The keyframe table is
// filled to the top and past it. Playback runs at several segment lengths,
// 0, 1 and 255 among them. A scoreboard keeps its own pose, table and
// increment state, and checks every done pulse against its prediction.
// ---------------------------------------------------------------------------
typedef struct {
	logic [4:0][31:0] pose;
	bit               playing;
	logic [7:0]       total;
	kpi_pkg::status_t status;
} pose_result_t;

class pose_scoreboard;
	logic signed [31:0] frames[5][kpi_pkg::MAX_KEYS];
	logic signed [31:0] cur[5];
	logic signed [31:0] inc[5];
	int                 count;
	int                 seg;
	int                 steps_done;
	bit                 run;
	int                 seg_steps;
	int                 errors;
	pose_result_t       pending_q[$];

	function new();
		count = 0;
		seg = 0;
		steps_done = 0;
		run = 0;
		seg_steps = int'(kpi_pkg::STEPS_RESET);
		errors = 0;
		for (int c = 0; c < 5; c++) begin
			cur[c] = '0;
			inc[c] = '0;
		end
	endfunction

	function int eff_steps();
		return (seg_steps == 0) ? 1 : seg_steps;
	endfunction

	function void segment_incs();
		longint diff;
		for (int c = 0; c < 5; c++) begin
			diff = longint'(frames[c][seg + 1]) - longint'(frames[c][seg]);
			inc[c] = 32'(diff / longint'(eff_steps()));
		end
	endfunction

	function void note(kpi_pkg::opcode_t op, logic [4:0][31:0] keys);
		pose_result_t r;
		r.status = kpi_pkg::ST_OK;
		case (op)
			kpi_pkg::OP_TICK: begin
				if (run) begin
					if (steps_done >= eff_steps()) begin
						seg++;
						if (count < 2 || seg > count - 2) begin
							seg = 0;
							run = 0;
						end else begin
							steps_done = 0;
							segment_incs();
						end
					end else begin
						for (int c = 0; c < 5; c++)
							cur[c] = cur[c] + inc[c];
						steps_done = (steps_done + 1) & 255;
					end
				end
			end
			kpi_pkg::OP_APPEND: begin
				if (count >= kpi_pkg::MAX_KEYS) begin
					r.status = kpi_pkg::ST_FULL;
				end else begin
					for (int c = 0; c < 5; c++)
						frames[c][count] = keys[c];
					count++;
				end
			end
			kpi_pkg::OP_CLEAR: begin
				count = 0;
				seg = 0;
				steps_done = 0;
				run = 0;
			end
			default: begin
				if (run || count < 2) begin
					r.status = kpi_pkg::ST_REFUSED;
				end else begin
					for (int c = 0; c < 5; c++)
						cur[c] = frames[c][0];
					seg = 0;
					steps_done = 0;
					segment_incs();
					run = 1;
				end
			end
		endcase
		for (int c = 0; c < 5; c++)
			r.pose[c] = cur[c];
		r.playing = run;
		r.total = count[7:0];
		pending_q.insert(pending_q.size(), r);
	endfunction

	function void check(pose_result_t got);
		pose_result_t exp_r;
		if (pending_q.size() == 0) begin
			$display("%0t: unexpected result", $time);
			errors++;
			return;
		end
		exp_r = pending_q.pop_front();
		for (int c = 0; c < 5; c++)
			if (got.pose[c] !== exp_r.pose[c]) begin
				$display("%0t: pose channel %0d expected %h actual %h", $time, c,
					exp_r.pose[c], got.pose[c]);
				errors++;
			end
		if (got.playing !== exp_r.playing) begin
			$display("%0t: playing expected %b actual %b", $time, exp_r.playing,
				got.playing);
			errors++;
		end
		if (got.total !== exp_r.total) begin
			$display("%0t: frame_total expected %0d actual %0d", $time, exp_r.total,
				got.total);
			errors++;
		end
		if (got.status !== exp_r.status) begin
			$display("%0t: status expected %0d actual %0d", $time, exp_r.status,
				got.status);
			errors++;
		end
	endfunction
endclass

module keyframe_pose_interpolator_core_tb;
	localparam int CYCLE_LIMIT = 1_000_000;
	localparam int ITEM_TARGET = 1100;
	localparam int QUIET_FROM  = 950;

	logic               clk = 0;
	logic               arst_n = 0;
	logic               start = 0;
	logic               busy;
	logic [1:0]         opcode = kpi_pkg::OP_TICK;
	logic signed [31:0] key_x = '0, key_y = '0, key_z = '0;
	logic signed [31:0] key_heading = '0, key_gear = '0;
	logic               cfg_valid = 0;
	logic               cfg_ready;
	logic [7:0]         cfg_data = '0;
	logic               done;
	logic signed [31:0] pose_x, pose_y, pose_z, pose_heading, pose_gear;
	logic               playing;
	logic [7:0]         frame_total;
	logic [1:0]         status;

	pose_scoreboard sb = new();
	int  cycles = 0;
	int  items = 0;
	bit  req_taken = 0;
	bit  cfg_taken = 0;

	keyframe_pose_interpolator_core i_dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .opcode(opcode),
		.key_x(key_x), .key_y(key_y), .key_z(key_z), .key_heading(key_heading),
		.key_gear(key_gear), .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_data(cfg_data), .done(done), .pose_x(pose_x), .pose_y(pose_y),
		.pose_z(pose_z), .pose_heading(pose_heading), .pose_gear(pose_gear),
		.playing(playing), .frame_total(frame_total), .status(status)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		pose_result_t got;
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("keyframe_pose_interpolator_core_tb: done, errors");
			$finish;
		end
		req_taken <= arst_n && start && !busy;
		cfg_taken <= arst_n && cfg_valid && cfg_ready;
		if (arst_n && start && !busy)
			sb.note(kpi_pkg::opcode_t'(opcode),
				{key_gear, key_heading, key_z, key_y, key_x});
		if (arst_n && cfg_valid && cfg_ready)
			sb.seg_steps = int'(cfg_data);
		if (arst_n && done) begin
			got.pose = {pose_gear, pose_heading, pose_z, pose_y, pose_x};
			got.playing = playing;
			got.total = frame_total;
			got.status = kpi_pkg::status_t'(status);
			sb.check(got);
		end
	end

	function automatic logic [31:0] rand_key();
		case ($urandom_range(0, 11))
			0: return 32'h7fff_ffff;
			1: return 32'h8000_0000;
			2: return 32'h0000_0000;
			3: return 32'hffff_ffff;
			default: return $urandom();
		endcase
	endfunction

	// one request, held until accepted, then an optional idle burst
	task automatic issue(kpi_pkg::opcode_t op, logic [4:0][31:0] keys);
		start = 1;
		opcode = op;
		{key_gear, key_heading, key_z, key_y, key_x} = keys;
		do @(negedge clk); while (!req_taken);
		items++;
		if (items < QUIET_FROM && $urandom_range(0, 4) == 0) begin
			start = 0;
			repeat ($urandom_range(1, 12)) @(negedge clk);
		end
	endtask

	task automatic issue_rand(kpi_pkg::opcode_t op);
		issue(op, {rand_key(), rand_key(), rand_key(), rand_key(), rand_key()});
	endtask

	task automatic drain();
		start = 0;
		while (sb.pending_q.size() != 0) @(negedge clk);
	endtask

	task automatic write_steps(logic [7:0] v);
		drain();
		cfg_valid = 1;
		cfg_data = v;
		do @(negedge clk); while (!cfg_taken);
		cfg_valid = 0;
	endtask

	initial begin
		int n_keys;
		int n_ticks;
		int pick;
		repeat (11) @(negedge clk);
		arst_n = 1;
		@(negedge clk);

		// directed: idle cases, reset length, wide keys at one step per segment
		issue(kpi_pkg::OP_TICK, '0);
		issue(kpi_pkg::OP_START, '0);
		issue(kpi_pkg::OP_APPEND, {5{32'h0123_4567}});
		issue(kpi_pkg::OP_APPEND, {5{32'hfedc_ba98}});
		issue(kpi_pkg::OP_START, '0);
		issue(kpi_pkg::OP_TICK, '0);
		issue(kpi_pkg::OP_TICK, '0);
		issue(kpi_pkg::OP_START, '0);
		issue(kpi_pkg::OP_CLEAR, '0);
		issue(kpi_pkg::OP_TICK, '0);
		issue(kpi_pkg::OP_START, '0);
		write_steps(8'd1);
		issue(kpi_pkg::OP_APPEND, {5{32'h7fff_ffff}});
		issue(kpi_pkg::OP_APPEND, {5{32'h8000_0000}});
		issue(kpi_pkg::OP_APPEND, {5{32'h7fff_ffff}});
		issue(kpi_pkg::OP_START, '0);
		issue(kpi_pkg::OP_TICK, '0);
		issue(kpi_pkg::OP_TICK, '0);
		issue(kpi_pkg::OP_APPEND, {5{32'h0000_0000}});
		issue(kpi_pkg::OP_TICK, '0);
		issue(kpi_pkg::OP_TICK, '0);
		issue(kpi_pkg::OP_TICK, '0);
		issue(kpi_pkg::OP_TICK, '0);
		issue(kpi_pkg::OP_TICK, '0);

		// full table
		write_steps(8'd0);
		issue(kpi_pkg::OP_CLEAR, '0);
		for (int i = 0; i < kpi_pkg::MAX_KEYS + 3; i++)
			issue_rand(kpi_pkg::OP_APPEND);
		issue(kpi_pkg::OP_START, '0);
		for (int i = 0; i < 12; i++)
			issue(kpi_pkg::OP_TICK, '0);

		while (items < ITEM_TARGET) begin
			pick = $urandom_range(0, 9);
			write_steps(pick == 0 ? 8'd0 : pick == 1 ? 8'd255 : pick == 2 ?
				8'($urandom()) : 8'($urandom_range(1, 6)));
			if ($urandom_range(0, 3) != 0)
				issue(kpi_pkg::OP_CLEAR, '0);
			n_keys = (sb.eff_steps() > 20) ? 2 : $urandom_range(2, 5);
			for (int i = 0; i < n_keys; i++)
				issue_rand(kpi_pkg::OP_APPEND);
			issue(kpi_pkg::OP_START, '0);
			n_ticks = $urandom_range(0, (sb.eff_steps() + 1) * n_keys + 4);
			if (n_ticks > 300)
				n_ticks = 300;
			for (int i = 0; i < n_ticks && items < ITEM_TARGET; i++)
				if ($urandom_range(0, 19) == 0)
					issue_rand(kpi_pkg::opcode_t'($urandom_range(1, 3)));
				else
					issue(kpi_pkg::OP_TICK, '0);
		end

		drain();
		repeat (400) @(negedge clk);
		if (sb.errors == 0 && sb.pending_q.size() == 0)
			$display("keyframe_pose_interpolator_core_tb: done, clean");
		else
			$display("keyframe_pose_interpolator_core_tb: done, errors");
		$finish;
	end
endmodule

>>> files.f
hdl/kpi_pkg.sv
hdl/kpi_ram.sv
hdl/kpi_div.sv
hdl/keyframe_pose_interpolator_core.sv
verif/keyframe_pose_interpolator_core_tb.sv
